### hdl/obb_sat_pkg.sv
package obb_sat_pkg;

  // fixed field widths
  localparam int AXIS_W    = 16;
  localparam int NORM_W    = AXIS_W + 1;
  localparam int HALF_W    = 20;
  localparam int DEPTH_W   = 23;
  localparam int NUM_AXES  = 4;
  localparam int GRAW_W    = 2 * NORM_W + 1;
  localparam int PROD_W    = NORM_W + DEPTH_W + 1;
  localparam int DEPTH_MAX = 4194304;
  localparam int NORM_MAX  = 32767;

  typedef logic signed [NORM_W-1:0] norm_t;
  typedef logic [HALF_W-1:0]        half_t;
  typedef logic [DEPTH_W-1:0]       depth_t;

endpackage

### hdl/obb_sat_proj.sv
module obb_sat_proj
  import obb_sat_pkg::*;
#(
  parameter int POS_WIDTH      = 24,
  parameter int AXIS_FRAC_BITS = 14,
  localparam int DW  = POS_WIDTH + 19,
  localparam int GAW = GRAW_W - AXIS_FRAC_BITS,
  localparam int RW  = HALF_W + GAW + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_v,
  input  logic signed [POS_WIDTH-1:0] a_pos_x,
  input  logic signed [POS_WIDTH-1:0] a_pos_y,
  input  half_t                       a_half_x,
  input  half_t                       a_half_y,
  input  logic signed [AXIS_W-1:0]    a_cos,
  input  logic signed [AXIS_W-1:0]    a_sin,
  input  logic signed [POS_WIDTH-1:0] b_pos_x,
  input  logic signed [POS_WIDTH-1:0] b_pos_y,
  input  half_t                       b_half_x,
  input  half_t                       b_half_y,
  input  logic signed [AXIS_W-1:0]    b_cos,
  input  logic signed [AXIS_W-1:0]    b_sin,
  output logic                        out_v,
  output logic signed [DW-1:0]        d [NUM_AXES],
  output logic [RW-1:0]               ra [NUM_AXES],
  output logic [RW-1:0]               rb [NUM_AXES],
  output norm_t                       nx [NUM_AXES],
  output norm_t                       ny [NUM_AXES],
  output logic signed [POS_WIDTH-1:0] pax,
  output logic signed [POS_WIDTH-1:0] pay
);

  localparam logic signed [GRAW_W-1:0] G_HALF = GRAW_W'(1 << (AXIS_FRAC_BITS - 1));

  // stage 1 registers
  logic                         v1_r;
  logic signed [POS_WIDTH:0]    dx_r, dy_r;
  logic signed [GRAW_W-1:0]     graw_r [NUM_AXES][4];
  norm_t                        nx1_r [NUM_AXES], ny1_r [NUM_AXES];
  half_t                        hax1_r, hay1_r, hbx1_r, hby1_r;
  logic signed [POS_WIDTH-1:0]  pax1_r, pay1_r;
  // stage 2 registers
  logic                         v2_r;
  logic signed [DW-1:0]         d2_r [NUM_AXES];
  logic [GAW-1:0]               gabs_r [NUM_AXES][4];
  norm_t                        nx2_r [NUM_AXES], ny2_r [NUM_AXES];
  half_t                        hax2_r, hay2_r, hbx2_r, hby2_r;
  logic signed [POS_WIDTH-1:0]  pax2_r, pay2_r;
  // stage 3 registers
  logic                         v3_r;
  logic signed [DW-1:0]         d3_r [NUM_AXES];
  logic [RW-1:0]                ra_r [NUM_AXES], rb_r [NUM_AXES];
  norm_t                        nx3_r [NUM_AXES], ny3_r [NUM_AXES];
  logic signed [POS_WIDTH-1:0]  pax3_r, pay3_r;

  norm_t                        nx_nxt [NUM_AXES], ny_nxt [NUM_AXES];
  logic signed [GRAW_W-1:0]     graw_nxt [NUM_AXES][4];
  logic signed [DW-1:0]         d_nxt [NUM_AXES];
  logic [GAW-1:0]               gabs_nxt [NUM_AXES][4];
  logic [RW-1:0]                ra_nxt [NUM_AXES], rb_nxt [NUM_AXES];
  norm_t                        ac, as, bc, bs;

  // axes and box-axis dot products
  always_comb begin
    ac = NORM_W'(a_cos);
    as = NORM_W'(a_sin);
    bc = NORM_W'(b_cos);
    bs = NORM_W'(b_sin);
    nx_nxt[0] = ac;  ny_nxt[0] = as;
    nx_nxt[1] = -as; ny_nxt[1] = ac;
    nx_nxt[2] = bc;  ny_nxt[2] = bs;
    nx_nxt[3] = -bs; ny_nxt[3] = bc;
    for (int i = 0; i < NUM_AXES; i++) begin
      graw_nxt[i][0] = ac * nx_nxt[i] + as * ny_nxt[i];
      graw_nxt[i][1] = ac * ny_nxt[i] - as * nx_nxt[i];
      graw_nxt[i][2] = bc * nx_nxt[i] + bs * ny_nxt[i];
      graw_nxt[i][3] = bc * ny_nxt[i] - bs * nx_nxt[i];
    end
  end

  // centre distance projection and rounded magnitudes
  always_comb begin
    logic signed [GRAW_W-1:0] gr;
    gr = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      d_nxt[i] = dx_r * nx1_r[i] + dy_r * ny1_r[i];
      for (int k = 0; k < 4; k++) begin
        gr = (graw_r[i][k] + G_HALF) >>> AXIS_FRAC_BITS;
        gabs_nxt[i][k] = gr[GRAW_W-1] ? GAW'(-gr) : GAW'(gr);
      end
    end
  end

  // projected radii
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      ra_nxt[i] = hax2_r * gabs_r[i][0] + hay2_r * gabs_r[i][1];
      rb_nxt[i] = hbx2_r * gabs_r[i][2] + hby2_r * gabs_r[i][3];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // data path
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r   <= (POS_WIDTH+1)'(b_pos_x) - (POS_WIDTH+1)'(a_pos_x);
      dy_r   <= (POS_WIDTH+1)'(b_pos_y) - (POS_WIDTH+1)'(a_pos_y);
      hax1_r <= a_half_x;
      hay1_r <= a_half_y;
      hbx1_r <= b_half_x;
      hby1_r <= b_half_y;
      pax1_r <= a_pos_x;
      pay1_r <= a_pos_y;
      hax2_r <= hax1_r;
      hay2_r <= hay1_r;
      hbx2_r <= hbx1_r;
      hby2_r <= hby1_r;
      pax2_r <= pax1_r;
      pay2_r <= pay1_r;
      pax3_r <= pax2_r;
      pay3_r <= pay2_r;
      for (int i = 0; i < NUM_AXES; i++) begin
        nx1_r[i] <= nx_nxt[i];
        ny1_r[i] <= ny_nxt[i];
        nx2_r[i] <= nx1_r[i];
        ny2_r[i] <= ny1_r[i];
        nx3_r[i] <= nx2_r[i];
        ny3_r[i] <= ny2_r[i];
        d2_r[i]  <= d_nxt[i];
        d3_r[i]  <= d2_r[i];
        ra_r[i]  <= ra_nxt[i];
        rb_r[i]  <= rb_nxt[i];
        for (int k = 0; k < 4; k++) begin
          graw_r[i][k] <= graw_nxt[i][k];
          gabs_r[i][k] <= gabs_nxt[i][k];
        end
      end
    end
  end

  assign out_v = v3_r;
  assign d     = d3_r;
  assign ra    = ra_r;
  assign rb    = rb_r;
  assign nx    = nx3_r;
  assign ny    = ny3_r;
  assign pax   = pax3_r;
  assign pay   = pay3_r;

endmodule

### hdl/obb_sat_ovl.sv
module obb_sat_ovl
  import obb_sat_pkg::*;
#(
  parameter int POS_WIDTH      = 24,
  parameter int AXIS_FRAC_BITS = 14,
  localparam int DW  = POS_WIDTH + 19,
  localparam int GAW = GRAW_W - AXIS_FRAC_BITS,
  localparam int RW  = HALF_W + GAW + 1,
  localparam int CW  = ((DW > RW + 1) ? DW : RW + 1) + 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_v,
  input  logic signed [DW-1:0]        d [NUM_AXES],
  input  logic [RW-1:0]               ra [NUM_AXES],
  input  logic [RW-1:0]               rb [NUM_AXES],
  input  norm_t                       nx [NUM_AXES],
  input  norm_t                       ny [NUM_AXES],
  input  logic signed [POS_WIDTH-1:0] pax,
  input  logic signed [POS_WIDTH-1:0] pay,
  output logic                        out_v,
  output logic signed [CW-1:0]        ov [NUM_AXES],
  output logic                        sep,
  output logic                        dpos [NUM_AXES],
  output norm_t                       onx [NUM_AXES],
  output norm_t                       ony [NUM_AXES],
  output logic signed [POS_WIDTH-1:0] opax,
  output logic signed [POS_WIDTH-1:0] opay
);

  // stage 4 registers
  logic                         v4_r;
  logic                         sep4_r [NUM_AXES];
  logic signed [CW-1:0]         hi_r [NUM_AXES], lo_r [NUM_AXES];
  logic                         dpos4_r [NUM_AXES];
  norm_t                        nx4_r [NUM_AXES], ny4_r [NUM_AXES];
  logic signed [POS_WIDTH-1:0]  pax4_r, pay4_r;
  // stage 5 registers
  logic                         v5_r;
  logic                         sep5_r;
  logic signed [CW-1:0]         ov_r [NUM_AXES];
  logic                         dpos5_r [NUM_AXES];
  norm_t                        nx5_r [NUM_AXES], ny5_r [NUM_AXES];
  logic signed [POS_WIDTH-1:0]  pax5_r, pay5_r;

  logic                         sep_nxt [NUM_AXES];
  logic signed [CW-1:0]         hi_nxt [NUM_AXES], lo_nxt [NUM_AXES];
  logic                         sep_any;

  // gap test and interval ends per axis
  always_comb begin
    logic signed [CW-1:0] de, ras, rbs, sum, dabs, dp, dm;
    de = '0; ras = '0; rbs = '0; sum = '0; dabs = '0; dp = '0; dm = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      de   = CW'(d[i]);
      ras  = CW'($signed({1'b0, ra[i]}));
      rbs  = CW'($signed({1'b0, rb[i]}));
      sum  = ras + rbs;
      dabs = de[CW-1] ? -de : de;
      dp   = de + rbs;
      dm   = de - rbs;
      sep_nxt[i] = dabs > sum;
      hi_nxt[i]  = (ras < dp) ? ras : dp;
      lo_nxt[i]  = (-ras > dm) ? -ras : dm;
    end
  end

  // any axis with a gap
  always_comb begin
    sep_any = 1'b0;
    for (int i = 0; i < NUM_AXES; i++) begin
      sep_any = sep_any | sep4_r[i];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v4_r <= in_v;
      v5_r <= v4_r;
    end
  end

  // data path
  always_ff @(posedge clk) begin
    if (en) begin
      pax4_r <= pax;
      pay4_r <= pay;
      pax5_r <= pax4_r;
      pay5_r <= pay4_r;
      sep5_r <= sep_any;
      for (int i = 0; i < NUM_AXES; i++) begin
        sep4_r[i]  <= sep_nxt[i];
        hi_r[i]    <= hi_nxt[i];
        lo_r[i]    <= lo_nxt[i];
        dpos4_r[i] <= d[i] > 0;
        nx4_r[i]   <= nx[i];
        ny4_r[i]   <= ny[i];
        ov_r[i]    <= hi_r[i] - lo_r[i];
        dpos5_r[i] <= dpos4_r[i];
        nx5_r[i]   <= nx4_r[i];
        ny5_r[i]   <= ny4_r[i];
      end
    end
  end

  assign out_v = v5_r;
  assign ov    = ov_r;
  assign sep   = sep5_r;
  assign dpos  = dpos5_r;
  assign onx   = nx5_r;
  assign ony   = ny5_r;
  assign opax  = pax5_r;
  assign opay  = pay5_r;

endmodule

### hdl/obb_sat_resolve.sv
module obb_sat_resolve
  import obb_sat_pkg::*;
#(
  parameter int POS_WIDTH      = 24,
  parameter int AXIS_FRAC_BITS = 14,
  localparam int DW  = POS_WIDTH + 19,
  localparam int GAW = GRAW_W - AXIS_FRAC_BITS,
  localparam int RW  = HALF_W + GAW + 1,
  localparam int CW  = ((DW > RW + 1) ? DW : RW + 1) + 2,
  localparam int SW  = ((PROD_W > POS_WIDTH) ? PROD_W : POS_WIDTH) + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_v,
  input  logic signed [CW-1:0]        ov [NUM_AXES],
  input  logic                        sep,
  input  logic                        dpos [NUM_AXES],
  input  norm_t                       nx [NUM_AXES],
  input  norm_t                       ny [NUM_AXES],
  input  logic signed [POS_WIDTH-1:0] pax,
  input  logic signed [POS_WIDTH-1:0] pay,
  output logic                        out_v,
  output logic                        hit,
  output logic signed [AXIS_W-1:0]    normal_x,
  output logic signed [AXIS_W-1:0]    normal_y,
  output depth_t                      depth,
  output logic signed [POS_WIDTH-1:0] new_a_x,
  output logic signed [POS_WIDTH-1:0] new_a_y
);

  localparam logic signed [CW-1:0]     C_HALF  = CW'(1 << (AXIS_FRAC_BITS - 1));
  localparam logic signed [PROD_W-1:0] P_HALF  = PROD_W'(1 << (AXIS_FRAC_BITS - 1));
  localparam logic signed [CW-1:0]     C_DMAX  = CW'(DEPTH_MAX);
  localparam logic signed [SW-1:0]     S_MAX   = SW'((64'sd1 <<< (POS_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SW-1:0]     S_MIN   = -S_MAX - SW'(1);
  localparam norm_t                    N_MAX   = NORM_W'(NORM_MAX);

  // stage 6: winners of each axis pair
  logic                        v6_r, sep6_r;
  logic signed [CW-1:0]        ov6_r [2];
  logic                        dpos6_r [2];
  norm_t                       nx6_r [2], ny6_r [2];
  logic signed [POS_WIDTH-1:0] pax6_r, pay6_r;
  // stage 7: chosen axis, depth
  logic                        v7_r, hit7_r;
  depth_t                      depth7_r;
  norm_t                       nx7_r, ny7_r;
  logic signed [POS_WIDTH-1:0] pax7_r, pay7_r;
  // stage 8: push products
  logic                        v8_r, hit8_r;
  depth_t                      depth8_r;
  norm_t                       nx8_r, ny8_r;
  logic signed [PROD_W-1:0]    px_r, py_r;
  logic signed [POS_WIDTH-1:0] pax8_r, pay8_r;
  // stage 9: output register
  logic                        v9_r, hit9_r;
  depth_t                      depth9_r;
  logic signed [AXIS_W-1:0]    nx9_r, ny9_r;
  logic signed [POS_WIDTH-1:0] nax_r, nay_r;

  logic                        pick_nxt [2];
  logic                        fin;
  norm_t                       bnx_nxt, bny_nxt;
  depth_t                      depth_nxt;
  logic signed [SW-1:0]        nax_nxt, nay_nxt;

  // earliest axis wins on ties
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      pick_nxt[j] = ov[2*j+1] < ov[2*j];
    end
  end

  // final pick, flip away from b, depth rounding
  always_comb begin
    logic signed [CW-1:0] dr;
    norm_t sx, sy;
    fin = ov6_r[1] < ov6_r[0];
    sx  = fin ? nx6_r[1] : nx6_r[0];
    sy  = fin ? ny6_r[1] : ny6_r[0];
    if (fin ? dpos6_r[1] : dpos6_r[0]) begin
      sx = -sx;
      sy = -sy;
    end
    dr = ((fin ? ov6_r[1] : ov6_r[0]) + C_HALF) >>> AXIS_FRAC_BITS;
    if (sep6_r) begin
      bnx_nxt   = '0;
      bny_nxt   = '0;
      depth_nxt = '0;
    end else begin
      bnx_nxt   = sx;
      bny_nxt   = sy;
      depth_nxt = (dr > C_DMAX) ? DEPTH_W'(DEPTH_MAX) : dr[DEPTH_W-1:0];
    end
  end

  // corrected centre with saturation
  always_comb begin
    logic signed [SW-1:0] sx, sy;
    sx = SW'(pax8_r) + SW'((px_r + P_HALF) >>> AXIS_FRAC_BITS);
    sy = SW'(pay8_r) + SW'((py_r + P_HALF) >>> AXIS_FRAC_BITS);
    nax_nxt = (sx > S_MAX) ? S_MAX : ((sx < S_MIN) ? S_MIN : sx);
    nay_nxt = (sy > S_MAX) ? S_MAX : ((sy < S_MIN) ? S_MIN : sy);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      v9_r <= 1'b0;
    end else if (en) begin
      v6_r <= in_v;
      v7_r <= v6_r;
      v8_r <= v7_r;
      v9_r <= v8_r;
    end
  end

  // data path
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        ov6_r[j]   <= pick_nxt[j] ? ov[2*j+1]   : ov[2*j];
        dpos6_r[j] <= pick_nxt[j] ? dpos[2*j+1] : dpos[2*j];
        nx6_r[j]   <= pick_nxt[j] ? nx[2*j+1]   : nx[2*j];
        ny6_r[j]   <= pick_nxt[j] ? ny[2*j+1]   : ny[2*j];
      end
      sep6_r   <= sep;
      pax6_r   <= pax;
      pay6_r   <= pay;
      hit7_r   <= !sep6_r;
      depth7_r <= depth_nxt;
      nx7_r    <= bnx_nxt;
      ny7_r    <= bny_nxt;
      pax7_r   <= pax6_r;
      pay7_r   <= pay6_r;
      hit8_r   <= hit7_r;
      depth8_r <= depth7_r;
      nx8_r    <= nx7_r;
      ny8_r    <= ny7_r;
      px_r     <= nx7_r * $signed({1'b0, depth7_r});
      py_r     <= ny7_r * $signed({1'b0, depth7_r});
      pax8_r   <= pax7_r;
      pay8_r   <= pay7_r;
      hit9_r   <= hit8_r;
      depth9_r <= depth8_r;
      nx9_r    <= (nx8_r > N_MAX) ? AXIS_W'(NORM_MAX) : nx8_r[AXIS_W-1:0];
      ny9_r    <= (ny8_r > N_MAX) ? AXIS_W'(NORM_MAX) : ny8_r[AXIS_W-1:0];
      nax_r    <= nax_nxt[POS_WIDTH-1:0];
      nay_r    <= nay_nxt[POS_WIDTH-1:0];
    end
  end

  assign out_v    = v9_r;
  assign hit      = hit9_r;
  assign normal_x = nx9_r;
  assign normal_y = ny9_r;
  assign depth    = depth9_r;
  assign new_a_x  = nax_r;
  assign new_a_y  = nay_r;

endmodule

### hdl/obb_obb_sat_collision.sv
// channel   direction  handshake              payload
// in_       input      in_valid / in_stall    two boxes: centre, half size, cos, sin
// out_      output     out_valid / out_stall  hit, normal, depth, corrected centre of a
//
// one transaction per cycle sustained while the output is not stalled
// nine register stages: products, rounded dot products, radii, interval ends,
// overlaps, pair pick, final pick and depth, push products, output register
// reset clears the valid bits of every stage
// a stall on a valid output freezes the whole pipeline, in_stall follows at once
module obb_obb_sat_collision
  import obb_sat_pkg::*;
#(
  parameter int POS_WIDTH      = 24,
  parameter int AXIS_FRAC_BITS = 14
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [POS_WIDTH-1:0] in_a_pos_x,
  input  logic signed [POS_WIDTH-1:0] in_a_pos_y,
  input  half_t                       in_a_half_x,
  input  half_t                       in_a_half_y,
  input  logic signed [AXIS_W-1:0]    in_a_cos,
  input  logic signed [AXIS_W-1:0]    in_a_sin,
  input  logic signed [POS_WIDTH-1:0] in_b_pos_x,
  input  logic signed [POS_WIDTH-1:0] in_b_pos_y,
  input  half_t                       in_b_half_x,
  input  half_t                       in_b_half_y,
  input  logic signed [AXIS_W-1:0]    in_b_cos,
  input  logic signed [AXIS_W-1:0]    in_b_sin,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_hit,
  output logic signed [AXIS_W-1:0]    out_normal_x,
  output logic signed [AXIS_W-1:0]    out_normal_y,
  output depth_t                      out_depth,
  output logic signed [POS_WIDTH-1:0] out_new_a_x,
  output logic signed [POS_WIDTH-1:0] out_new_a_y
);

  localparam int DW  = POS_WIDTH + 19;
  localparam int GAW = GRAW_W - AXIS_FRAC_BITS;
  localparam int RW  = HALF_W + GAW + 1;
  localparam int CW  = ((DW > RW + 1) ? DW : RW + 1) + 2;

  logic                        en;
  logic                        pv, ovv, sep;
  logic signed [DW-1:0]        d [NUM_AXES];
  logic [RW-1:0]               ra [NUM_AXES], rb [NUM_AXES];
  norm_t                       nx [NUM_AXES], ny [NUM_AXES];
  norm_t                       onx [NUM_AXES], ony [NUM_AXES];
  logic signed [CW-1:0]        ov [NUM_AXES];
  logic                        dpos [NUM_AXES];
  logic signed [POS_WIDTH-1:0] pax, pay, opax, opay;

  // pipeline advance
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  obb_sat_proj #(.POS_WIDTH(POS_WIDTH), .AXIS_FRAC_BITS(AXIS_FRAC_BITS)) u_proj (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(in_valid),
    .a_pos_x(in_a_pos_x), .a_pos_y(in_a_pos_y),
    .a_half_x(in_a_half_x), .a_half_y(in_a_half_y),
    .a_cos(in_a_cos), .a_sin(in_a_sin),
    .b_pos_x(in_b_pos_x), .b_pos_y(in_b_pos_y),
    .b_half_x(in_b_half_x), .b_half_y(in_b_half_y),
    .b_cos(in_b_cos), .b_sin(in_b_sin),
    .out_v(pv), .d(d), .ra(ra), .rb(rb), .nx(nx), .ny(ny), .pax(pax), .pay(pay)
  );

  obb_sat_ovl #(.POS_WIDTH(POS_WIDTH), .AXIS_FRAC_BITS(AXIS_FRAC_BITS)) u_ovl (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(pv),
    .d(d), .ra(ra), .rb(rb), .nx(nx), .ny(ny), .pax(pax), .pay(pay),
    .out_v(ovv), .ov(ov), .sep(sep), .dpos(dpos), .onx(onx), .ony(ony),
    .opax(opax), .opay(opay)
  );

  obb_sat_resolve #(.POS_WIDTH(POS_WIDTH), .AXIS_FRAC_BITS(AXIS_FRAC_BITS)) u_resolve (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(ovv),
    .ov(ov), .sep(sep), .dpos(dpos), .nx(onx), .ny(ony), .pax(opax), .pay(opay),
    .out_v(out_valid), .hit(out_hit), .normal_x(out_normal_x),
    .normal_y(out_normal_y), .depth(out_depth),
    .new_a_x(out_new_a_x), .new_a_y(out_new_a_y)
  );

`ifndef ASSERT_OFF
  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a miss carries no normal and no depth
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_depth == '0 && out_normal_x == '0 && out_normal_y == '0)
    else $error("miss with nonzero normal or depth");

  // depth saturates
  a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_depth <= DEPTH_W'(DEPTH_MAX))
    else $error("depth above saturation limit");
`endif

endmodule

### test/tb_obb_obb_sat_collision.sv
module tb_obb_obb_sat_collision
  import obb_sat_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW = 24;
  localparam int FB = 14;
  localparam int STALL_LIMIT = 20000;

  // one box pair
  typedef struct {
    logic signed [PW-1:0] apx, apy, bpx, bpy;
    half_t ahx, ahy, bhx, bhy;
    logic signed [AXIS_W-1:0] ac, as_, bc, bs;
  } box_pair_t;

  // one collision verdict
  typedef struct {
    logic hit;
    logic signed [AXIS_W-1:0] nx, ny;
    depth_t depth;
    logic signed [PW-1:0] ax, ay;
  } contact_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [PW-1:0] in_a_pos_x = 0, in_a_pos_y = 0, in_b_pos_x = 0, in_b_pos_y = 0;
  half_t in_a_half_x = 0, in_a_half_y = 0, in_b_half_x = 0, in_b_half_y = 0;
  logic signed [AXIS_W-1:0] in_a_cos = 0, in_a_sin = 0, in_b_cos = 0, in_b_sin = 0;
  logic out_valid;
  logic out_stall = 0;
  logic out_hit;
  logic signed [AXIS_W-1:0] out_normal_x, out_normal_y;
  depth_t out_depth;
  logic signed [PW-1:0] out_new_a_x, out_new_a_y;

  contact_t contact_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_off = 0;
  bit hold_go = 0;
  bit hold_seen = 0;

  always #5 clk = ~clk;

  obb_obb_sat_collision uut (.*);

  // rounding of a Q(2F) value to Q(F), floor shift
  function automatic longint round_axis(longint x);
    return (x + (longint'(1) << (FB - 1))) >>> FB;
  endfunction

  function automatic longint babs(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint box_radius(longint hx, longint hy, longint cx, longint sy,
                                        longint nx, longint ny);
    longint g0, g1;
    g0 = round_axis(cx * nx + sy * ny);
    g1 = round_axis(-sy * nx + cx * ny);
    return hx * babs(g0) + hy * babs(g1);
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  // separating axis prediction
  function automatic contact_t predict_contact(box_pair_t p);
    contact_t r;
    longint axx[4], axy[4];
    longint dx, dy, d, ra, rb, hi, lo, ov, best, bnx, bny, bd, dep, pmax, pmin;
    bit have;
    pmax = (longint'(1) << (PW - 1)) - 1;
    pmin = -pmax - 1;
    dx = longint'(p.bpx) - longint'(p.apx);
    dy = longint'(p.bpy) - longint'(p.apy);
    axx[0] = longint'(p.ac);   axy[0] = longint'(p.as_);
    axx[1] = -longint'(p.as_); axy[1] = longint'(p.ac);
    axx[2] = longint'(p.bc);   axy[2] = longint'(p.bs);
    axx[3] = -longint'(p.bs);  axy[3] = longint'(p.bc);
    have = 0; best = 0; bnx = 0; bny = 0; bd = 0;
    r.hit = 0; r.nx = 0; r.ny = 0; r.depth = 0; r.ax = p.apx; r.ay = p.apy;
    for (int i = 0; i < 4; i++) begin
      d = dx * axx[i] + dy * axy[i];
      ra = box_radius(longint'(p.ahx), longint'(p.ahy), longint'(p.ac), longint'(p.as_),
                      axx[i], axy[i]);
      rb = box_radius(longint'(p.bhx), longint'(p.bhy), longint'(p.bc), longint'(p.bs),
                      axx[i], axy[i]);
      if (d > ra + rb || -d > ra + rb) return r;
      hi = ra < d + rb ? ra : d + rb;
      lo = -ra > d - rb ? -ra : d - rb;
      ov = hi - lo;
      if (!have || ov < best) begin
        have = 1; best = ov; bnx = axx[i]; bny = axy[i]; bd = d;
      end
    end
    if (bd > 0) begin
      bnx = -bnx;
      bny = -bny;
    end
    dep = clip(round_axis(best), 0, DEPTH_MAX);
    r.hit = 1;
    r.nx = AXIS_W'(clip(bnx, -32768, NORM_MAX));
    r.ny = AXIS_W'(clip(bny, -32768, NORM_MAX));
    r.depth = DEPTH_W'(dep);
    r.ax = PW'(clip(longint'(p.apx) + round_axis(bnx * dep), pmin, pmax));
    r.ay = PW'(clip(longint'(p.apy) + round_axis(bny * dep), pmin, pmax));
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // send one box pair, random idle gap first
  task automatic send_pair(box_pair_t p);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_a_pos_x <= p.apx; in_a_pos_y <= p.apy;
    in_a_half_x <= p.ahx; in_a_half_y <= p.ahy;
    in_a_cos <= p.ac; in_a_sin <= p.as_;
    in_b_pos_x <= p.bpx; in_b_pos_y <= p.bpy;
    in_b_half_x <= p.bhx; in_b_half_y <= p.bhy;
    in_b_cos <= p.bc; in_b_sin <= p.bs;
    contact_q.push_back(predict_contact(p));
    do @(posedge clk); while (in_stall);
  endtask

  function automatic box_pair_t rand_pair(bit close_pair);
    box_pair_t p;
    int sc;
    sc = $urandom_range(3);
    p.apx = PW'($urandom); p.apy = PW'($urandom);
    p.ahx = HALF_W'($urandom); p.ahy = HALF_W'($urandom);
    p.bhx = HALF_W'($urandom); p.bhy = HALF_W'($urandom);
    p.ac = AXIS_W'($urandom); p.as_ = AXIS_W'($urandom);
    p.bc = AXIS_W'($urandom); p.bs = AXIS_W'($urandom);
    p.bpx = PW'($urandom); p.bpy = PW'($urandom);
    if (close_pair) begin
      // centres near each other, mostly moderate sizes and axis components of magnitude at most one
      p.bpx = PW'(int'(p.apx) + int'($urandom_range(4095)) - 2048);
      p.bpy = PW'(int'(p.apy) + int'($urandom_range(4095)) - 2048);
      if (sc != 0) begin
        p.ahx = HALF_W'($urandom_range(2047)); p.ahy = HALF_W'($urandom_range(2047));
        p.bhx = HALF_W'($urandom_range(2047)); p.bhy = HALF_W'($urandom_range(2047));
      end
      if (sc < 3) begin
        p.ac = AXIS_W'(int'($urandom_range(32768)) - 16384);
        p.as_ = AXIS_W'(int'($urandom_range(32768)) - 16384);
        p.bc = AXIS_W'(int'($urandom_range(32768)) - 16384);
        p.bs = AXIS_W'(int'($urandom_range(32768)) - 16384);
      end
    end
    return p;
  endfunction

  function automatic box_pair_t mk(longint apx, longint apy, longint ah, longint ac,
                                   longint as_, longint bpx, longint bpy, longint bh,
                                   longint bc, longint bs);
    box_pair_t p;
    p.apx = PW'(apx); p.apy = PW'(apy); p.ahx = HALF_W'(ah); p.ahy = HALF_W'(ah);
    p.ac = AXIS_W'(ac); p.as_ = AXIS_W'(as_);
    p.bpx = PW'(bpx); p.bpy = PW'(bpy); p.bhx = HALF_W'(bh); p.bhy = HALF_W'(bh);
    p.bc = AXIS_W'(bc); p.bs = AXIS_W'(bs);
    return p;
  endfunction

  // directed corners of the field ranges
  task automatic test_directed();
    send_pair(mk(0, 0, 256, 16384, 0, 256, 0, 256, 16384, 0));
    send_pair(mk(0, 0, 256, 16384, 0, 2000, 0, 256, 16384, 0));
    send_pair(mk(0, 0, 0, 16384, 0, 0, 0, 0, 16384, 0));
    send_pair(mk(0, 0, 0, 16384, 0, 10, 0, 0, 16384, 0));
    send_pair(mk(0, 0, 256, 16384, 0, 512, 0, 256, 16384, 0));
    send_pair(mk(100, -50, 300, 11585, 11585, 50, 20, 300, 16384, 0));
    send_pair(mk(0, 0, 1048575, -16384, -16384, 0, 0, 1048575, 16384, 16384));
    send_pair(mk(-32768 * 256, 0, 1048575, 16384, 0, 100, 5, 1048575, 16384, 0));
    send_pair(mk(8388607, 8388607, 1048575, 16384, 0, 8388600, 8388600, 1048575,
                 16384, 0));
    send_pair(mk(-8388608, -8388608, 1048575, 16384, 0, -8388600, -8388600, 1048575,
                 16384, 0));
    send_pair(mk(0, 0, 500, -32768, -32768, 10, 10, 500, -32768, 32767));
    send_pair(mk(0, 0, 500, 32767, -32768, -10, 10, 500, 0, 0));
    send_pair(mk(0, 0, 1048575, 32767, 32767, 1, 1, 1048575, -32768, -32768));
    send_pair(mk(8388607, -8388608, 0, 16384, 0, -8388608, 8388607, 0, 0, 16384));
    send_pair(mk(5, 5, 100, 0, 16384, 5, 5, 100, 0, -16384));
    send_pair(mk(0, 0, 256, 16384, 0, 0, 256, 256, 16384, 0));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_pair(rand_pair($urandom_range(9) < 8));
  endtask

  task automatic test_backpressure();
    stall_pct = 0;
    hold_go = 1;
    test_random(40);
  endtask

  // result checker
  always @(posedge clk) begin
    contact_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (contact_q.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        e = contact_q.pop_front();
        if (out_hit !== e.hit) report_mismatch("hit", out_hit, e.hit);
        if (out_normal_x !== e.nx) report_mismatch("normal_x", out_normal_x, e.nx);
        if (out_normal_y !== e.ny) report_mismatch("normal_y", out_normal_y, e.ny);
        if (out_depth !== e.depth) report_mismatch("depth", out_depth, e.depth);
        if (out_new_a_x !== e.ax) report_mismatch("new_a_x", out_new_a_x, e.ax);
        if (out_new_a_y !== e.ay) report_mismatch("new_a_y", out_new_a_y, e.ay);
      end
    end
  end

  // receiver stall, with one long hold-off stretch
  always @(posedge clk) begin
    if (hold_go && !hold_seen) begin
      hold_seen <= 1;
      hold_off <= 60;
      out_stall <= 1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1;
    end else begin
      out_stall <= stall_pct > 0 && $urandom_range(99) < stall_pct;
    end
  end

  // watchdog on accepted-transaction silence
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    send_idle_pct = 0;  stall_pct = 0;  test_random(120);
    send_idle_pct = 81; stall_pct = 0;  test_random(90);
    send_idle_pct = 0;  stall_pct = 81; test_random(90);
    send_idle_pct = 12; stall_pct = 12; test_random(120);
    send_idle_pct = 0;
    test_backpressure();
    in_valid <= 0;
    stall_pct = 0;
    while (contact_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
